// ----- rtl/swe_pkg.sv -----
// Shared types, constants and the level table of the sound channel word encoder.
// No dependencies.
package swe_pkg;

	localparam int unsigned RATE_W  = 21;
	localparam int unsigned BASE_W  = 23;
	localparam int unsigned MANT_W  = 10;
	localparam int unsigned DIV_W   = RATE_W + MANT_W;
	localparam int unsigned CNT_W   = $clog2(DIV_W);
	localparam int unsigned OCT_W   = 4;
	localparam int unsigned HALVE_MAX = 15;

	localparam logic [BASE_W-1:0] PITCH_BASE     = 23'd5644800;
	localparam logic [OCT_W-1:0]  OCT_START      = 4'd7;
	localparam logic [7:0]        PAN_CENTRE     = 8'h80;
	localparam logic [4:0]        PAN_CODE_MID   = 5'h00;
	localparam logic [4:0]        PAN_CODE_LEFT  = 5'h1f;
	localparam logic [4:0]        PAN_CODE_RIGHT = 5'h0f;
	localparam logic [1:0]        KEY_ON_BITS    = 2'b11;
	localparam logic [7:0]        LEVEL_FULL     = 8'hff;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} cmd_t;

	// upper half of the logarithmic volume curve
	localparam logic [7:0] LEVEL_ROM [128] = '{
		8'd180, 8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185,
		8'd186, 8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191, 8'd191,
		8'd192, 8'd193, 8'd193, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197, 8'd197,
		8'd198, 8'd199, 8'd199, 8'd200, 8'd200, 8'd201, 8'd202, 8'd202, 8'd203,
		8'd204, 8'd204, 8'd205, 8'd205, 8'd206, 8'd207, 8'd207, 8'd208, 8'd209,
		8'd209, 8'd210, 8'd210, 8'd211, 8'd212, 8'd212, 8'd213, 8'd213, 8'd214,
		8'd215, 8'd215, 8'd216, 8'd216, 8'd217, 8'd217, 8'd218, 8'd219, 8'd219,
		8'd220, 8'd220, 8'd221, 8'd221, 8'd222, 8'd223, 8'd223, 8'd224, 8'd224,
		8'd225, 8'd225, 8'd226, 8'd227, 8'd227, 8'd228, 8'd228, 8'd229, 8'd229,
		8'd230, 8'd230, 8'd231, 8'd232, 8'd232, 8'd233, 8'd233, 8'd234, 8'd234,
		8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd239, 8'd239,
		8'd240, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244,
		8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248,
		8'd249, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252, 8'd253,
		8'd254, 8'd255
	};

endpackage

// ----- rtl/swe_ctrl.sv -----
// Controller of the sound channel word encoder: sequences load, divide steps and capture.
// Depends on swe_pkg.
module swe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output swe_pkg::cmd_t cmd
);
	import swe_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = CNT_W'(DIV_W - 1);
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.capture = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIV && cnt_q == CNT_W'(DIV_W - 1)))
		else $error("accepted beat did not start the divider");

	a_div_runs_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q != '0) |=> (state_q == ST_DIV && cnt_q == $past(cnt_q) - 1'b1))
		else $error("divider left early or miscounted");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_DONE)
		else $error("divider did not finish after last step");

	a_capture_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || out_ready))
		else $error("result overwrote a beat not yet taken");
`endif

endmodule

// ----- rtl/swe_dpath.sv -----
// Datapath of the sound channel word encoder: octave search, restoring divider,
// level table, pan and key words, output register. Depends on swe_pkg.
module swe_dpath (
	input  logic          clk,
	input  swe_pkg::cmd_t cmd,
	input  logic [5:0]    channel,
	input  logic [20:0]   sample_addr,
	input  logic [1:0]    sample_format,
	input  logic          loop_enable,
	input  logic [15:0]   loop_start,
	input  logic [15:0]   loop_end,
	input  logic [20:0]   rate_hz,
	input  logic [7:0]    volume,
	input  logic [7:0]    pan,
	output logic [14:0]   pitch_word,
	output logic [7:0]    level_byte,
	output logic [4:0]    pan_byte,
	output logic [15:0]   start_addr_low,
	output logic [15:0]   key_word,
	output logic          key_word_valid,
	output logic [15:0]   loop_start_word,
	output logic [15:0]   loop_end_word
);
	import swe_pkg::*;

	logic [OCT_W-1:0]  halve;
	logic [BASE_W-1:0] base_d;
	logic [4:0]        pan_code;
	logic              key_ok;

	logic [DIV_W-1:0]  dvd_q;
	logic [BASE_W-1:0] base_q;
	logic [BASE_W-1:0] rem_q;
	logic [MANT_W-1:0] quot_q;
	logic [OCT_W-1:0]  oct_q;
	logic [BASE_W:0]   trial;
	logic              fits;

	logic [7:0]  level_q;
	logic [4:0]  pan_q;
	logic [15:0] addr_low_q, key_q, lstart_q, lend_q;
	logic        key_ok_q;

	// smallest number of halvings that brings the base down to the rate
	always_comb begin
		halve = OCT_W'(HALVE_MAX);
		for (int i = HALVE_MAX - 1; i >= 0; i--) begin
			if ({2'b00, rate_hz} >= (PITCH_BASE >> i)) begin
				halve = OCT_W'(i);
			end
		end
		base_d = PITCH_BASE >> halve;
	end

	always_comb begin
		if (pan == PAN_CENTRE) begin
			pan_code = PAN_CODE_MID;
		end else if (pan < PAN_CENTRE) begin
			pan_code = PAN_CODE_LEFT;
		end else begin
			pan_code = PAN_CODE_RIGHT;
		end
	end

	assign key_ok = channel >= 6'd2;
	assign trial  = {rem_q, dvd_q[DIV_W-1]};
	assign fits   = trial >= {1'b0, base_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q      <= {rate_hz, MANT_W'(0)};
			base_q     <= base_d;
			rem_q      <= '0;
			quot_q     <= '0;
			oct_q      <= OCT_START - halve;
			level_q    <= LEVEL_FULL - LEVEL_ROM[volume[7:1]];
			pan_q      <= pan_code;
			addr_low_q <= sample_addr[15:0];
			key_q      <= key_ok ? {KEY_ON_BITS, 4'b0000, loop_enable, sample_format,
			                        2'b00, sample_addr[20:16]} : 16'h0000;
			key_ok_q   <= key_ok;
			lstart_q   <= loop_start;
			lend_q     <= loop_end;
		end else if (cmd.step) begin
			// one quotient bit per step
			dvd_q  <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q  <= fits ? BASE_W'(trial - {1'b0, base_q}) : trial[BASE_W-1:0];
			quot_q <= {quot_q[MANT_W-2:0], fits};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pitch_word      <= {oct_q, 1'b0, quot_q};
			level_byte      <= level_q;
			pan_byte        <= pan_q;
			start_addr_low  <= addr_low_q;
			key_word        <= key_q;
			key_word_valid  <= key_ok_q;
			loop_start_word <= lstart_q;
			loop_end_word   <= lend_q;
		end
	end

endmodule

// ----- rtl/sound_channel_word_encoder.sv -----
// Top level of the sound channel word encoder: joins controller and datapath.
// Depends on swe_pkg, swe_ctrl and swe_dpath.
//
//  channel  handshake            payload
//  -------  -------------------  -------------------------------------------------
//  in       in_valid / in_ready  channel, sample_addr, sample_format, loop_enable,
//                                loop_start, loop_end, rate_hz, volume, pan
//  out      out_valid/out_ready  pitch_word, level_byte, pan_byte, start_addr_low,
//                                key_word, key_word_valid, loop_start_word,
//                                loop_end_word
//
// For each item the accepting edge loads the operands and picks the octave, the
// restoring divider then steps through the 31-bit dividend (one quotient bit per
// step), and the result moves into the output register once the output is free.
// Reset clears the controller and output valid; payload registers are not reset.
// A result waiting at the output does not stop the next beat from being taken;
// only a second finished result waits in the done state until the port drains.
module sound_channel_word_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  channel,
	input  logic [20:0] sample_addr,
	input  logic [1:0]  sample_format,
	input  logic        loop_enable,
	input  logic [15:0] loop_start,
	input  logic [15:0] loop_end,
	input  logic [20:0] rate_hz,
	input  logic [7:0]  volume,
	input  logic [7:0]  pan,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] pitch_word,
	output logic [7:0]  level_byte,
	output logic [4:0]  pan_byte,
	output logic [15:0] start_addr_low,
	output logic [15:0] key_word,
	output logic        key_word_valid,
	output logic [15:0] loop_start_word,
	output logic [15:0] loop_end_word
);
	import swe_pkg::*;

	cmd_t cmd;

	// sequence load, divide and capture
	swe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// hold operands, divide, and register the result beat
	swe_dpath u_dpath (
		.clk             (clk),
		.cmd             (cmd),
		.channel         (channel),
		.sample_addr     (sample_addr),
		.sample_format   (sample_format),
		.loop_enable     (loop_enable),
		.loop_start      (loop_start),
		.loop_end        (loop_end),
		.rate_hz         (rate_hz),
		.volume          (volume),
		.pan             (pan),
		.pitch_word      (pitch_word),
		.level_byte      (level_byte),
		.pan_byte        (pan_byte),
		.start_addr_low  (start_addr_low),
		.key_word        (key_word),
		.key_word_valid  (key_word_valid),
		.loop_start_word (loop_start_word),
		.loop_end_word   (loop_end_word)
	);

endmodule
